// ----- rtl/core/mlk_pkg.sv -----
// Shared types and constants for the multiplexed link receiver.
// Used by the controller, datapath and top level.
package mlk_pkg;

  localparam int IdBitsDefault = 16;

  localparam logic [7:0]  IdleTicksReset = 8'd60;
  localparam logic [7:0]  PingTicksReset = 8'd10;
  localparam logic [47:0] OpcodeSetReset = 48'd5514788471040;

  localparam logic [1:0] RegServerRole = 2'd0;
  localparam logic [1:0] RegIdleTicks  = 2'd1;
  localparam logic [1:0] RegPingTicks  = 2'd2;
  localparam logic [1:0] RegOpcodeSet  = 2'd3;

  localparam int OpcPing    = 0;
  localparam int OpcPong    = 1;
  localparam int OpcHello   = 2;
  localparam int OpcConnect = 3;
  localparam int OpcBye     = 4;
  localparam int OpcData    = 5;

  typedef enum logic [1:0] {
    OP_LINK   = 2'd0,
    OP_TICK   = 2'd1,
    OP_OPEN   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_CMD    = 2'd0,
    PH_CLIENT = 2'd1,
    PH_HDR    = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    K_NONE     = 4'd0,
    K_PONG     = 4'd1,
    K_PING     = 4'd2,
    K_IDLE     = 4'd3,
    K_ERR      = 4'd4,
    K_ADDED    = 4'd5,
    K_RESUME   = 4'd6,
    K_BYE      = 4'd7,
    K_DATA     = 4'd8,
    K_OPENED   = 4'd9,
    K_OPENFAIL = 4'd10,
    K_REMOVED  = 4'd11
  } kind_t;

  typedef enum logic [1:0] {
    C_NONE    = 2'd0,
    C_UNKNOWN = 2'd1,
    C_CLIENT  = 2'd2,
    C_DATA    = 2'd3
  } cause_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic scan_rd;
    logic scan_chk;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic open_scan;
    logic scan_wrap;
    logic scan_free;
  } sts_t;

endpackage

// ----- rtl/core/mlk_ifs.sv -----
// Request channel interfaces for the multiplexed link receiver.
// Depends on nothing; widths follow the item fields.
interface mlk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_in;
  logic [15:0] local_id;
  modport source (output valid, op, byte_in, local_id, input ready);
  modport sink (input valid, op, byte_in, local_id, output ready);
endinterface

interface mlk_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [15:0] conn_id;
  logic [7:0]  data_out;
  logic        last;
  logic [1:0]  error_cause;
  modport source (output valid, kind, conn_id, data_out, last, error_cause, input ready);
  modport sink (input valid, kind, conn_id, data_out, last, error_cause, output ready);
endinterface

// ----- rtl/core/mlk_ctrl.sv -----
// Controller state machine for the multiplexed link receiver.
// Depends on mlk_pkg for the command and status structs.
module mlk_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mlk_pkg::sts_t sts,
  output mlk_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_EXEC     = 6'b000100,
    S_SCAN_RD  = 6'b001000,
    S_SCAN_CHK = 6'b010000,
    S_OUT      = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = sts.open_scan ? S_SCAN_RD : S_OUT;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = sts.scan_wrap ? S_OUT : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_next = sts.scan_free ? S_OUT : S_SCAN_RD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.exec) else $error("accepted request not executed");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

// ----- rtl/core/mlk_dp.sv -----
// Datapath of the multiplexed link receiver: parser registers, id bitmap
// memory, idle counter, configuration and result register. Depends on mlk_pkg.
module mlk_dp #(
  parameter int IdBits = mlk_pkg::IdBitsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_byte,
  input  logic [15:0]   in_lid,
  input  mlk_pkg::cmd_t cmd,
  output mlk_pkg::sts_t sts,
  output logic [3:0]    o_kind,
  output logic [15:0]   o_conn,
  output logic [7:0]    o_data,
  output logic          o_last,
  output logic [1:0]    o_cause
);

  logic server_role;
  logic [7:0] idle_ticks, ping_ticks;
  logic [47:0] opcode_set;

  mlk_pkg::phase_t phase, phase_next;
  logic [1:0]  hdr, hdr_next;
  logic [7:0]  cmd_byte, cmd_byte_next;
  logic [15:0] cmd_id, cmd_id_next;
  logic [15:0] rem, rem_next;
  logic [7:0]  idle_cnt, idle_cnt_next;
  logic        closed, closed_next;
  logic [IdBits-1:0] next_id, next_id_next, first_id, first_id_next, cand, clr_addr;

  logic [1:0]  op_r;
  logic [7:0]  byte_r;
  logic [15:0] lid_r;

  logic mem [2**IdBits];
  logic mem_q, we, wd;
  logic [IdBits-1:0] wa, ra;

  logic [15:0] acc_id, ex_id;
  logic ex_ok, ld;
  mlk_pkg::kind_t  k_next;
  mlk_pkg::cause_t c_next;
  logic [15:0] conn_next, rem_dec;
  logic [7:0]  data_next, tick_cnt;
  logic        last_next;

  function automatic logic [15:0] pick_id(input logic [1:0] op, input logic [7:0] b,
                                          input logic [15:0] lid, input mlk_pkg::phase_t ph,
                                          input logic [15:0] cid);
    logic [15:0] r;
    r = cid;
    if (op == mlk_pkg::OP_REMOVE) r = lid;
    else if (op == mlk_pkg::OP_LINK && ph == mlk_pkg::PH_CLIENT) r = {cid[7:0], b};
    return r;
  endfunction

  function automatic logic [7:0] opc(input logic [47:0] set, input int n);
    return set[8*n +: 8];
  endfunction

  assign acc_id = pick_id(in_op, in_byte, in_lid, phase, cmd_id);
  assign ex_id  = pick_id(op_r, byte_r, lid_r, phase, cmd_id);
  assign ex_ok  = mem_q && ((32'(ex_id) >> IdBits) == 32'd0);
  assign cand   = next_id + 1'b1;
  assign rem_dec = rem - 16'd1;
  assign tick_cnt = idle_cnt - 8'd1;

  assign sts.clear_done = (clr_addr == '1);
  assign sts.open_scan  = !closed && op_r == mlk_pkg::OP_OPEN && server_role;
  assign sts.scan_wrap  = (cand == first_id);
  assign sts.scan_free  = !mem_q;

  always_comb begin
    phase_next = phase;
    hdr_next = hdr;
    cmd_byte_next = cmd_byte;
    cmd_id_next = cmd_id;
    rem_next = rem;
    idle_cnt_next = idle_cnt;
    closed_next = closed;
    next_id_next = next_id;
    first_id_next = first_id;
    we = 1'b0;
    wa = clr_addr;
    wd = 1'b0;
    ra = acc_id[IdBits-1:0];
    ld = 1'b0;
    k_next = mlk_pkg::K_NONE;
    c_next = mlk_pkg::C_NONE;
    conn_next = '0;
    data_next = '0;
    last_next = 1'b0;

    if (cmd.clear) we = 1'b1;

    if (cmd.exec && !closed) begin
      unique case (op_r)
        mlk_pkg::OP_LINK: begin
          idle_cnt_next = idle_ticks;
          unique case (phase)
            mlk_pkg::PH_CMD: begin
              cmd_byte_next = byte_r;
              hdr_next = 2'd0;
              priority if (byte_r == opc(opcode_set, mlk_pkg::OpcPing)) begin
                k_next = mlk_pkg::K_PONG;
              end else if (byte_r == opc(opcode_set, mlk_pkg::OpcPong)) begin
                k_next = mlk_pkg::K_NONE;
              end else if (byte_r == opc(opcode_set, mlk_pkg::OpcHello) ||
                           byte_r == opc(opcode_set, mlk_pkg::OpcConnect) ||
                           byte_r == opc(opcode_set, mlk_pkg::OpcBye)) begin
                phase_next = mlk_pkg::PH_CLIENT;
              end else if (byte_r == opc(opcode_set, mlk_pkg::OpcData)) begin
                phase_next = mlk_pkg::PH_HDR;
              end else begin
                closed_next = 1'b1;
                k_next = mlk_pkg::K_ERR;
                c_next = mlk_pkg::C_UNKNOWN;
              end
            end
            mlk_pkg::PH_CLIENT: begin
              cmd_id_next = ex_id;
              if (hdr == 2'd0) begin
                hdr_next = 2'd1;
              end else begin
                hdr_next = 2'd0;
                phase_next = mlk_pkg::PH_CMD;
                conn_next = ex_id;
                k_next = mlk_pkg::K_ERR;
                c_next = mlk_pkg::C_CLIENT;
                priority if (cmd_byte == opc(opcode_set, mlk_pkg::OpcHello)) begin
                  if (!server_role && !mem_q && (32'(ex_id) >> IdBits) == 32'd0) begin
                    we = 1'b1;
                    wa = ex_id[IdBits-1:0];
                    wd = 1'b1;
                    k_next = mlk_pkg::K_ADDED;
                  end
                end else if (cmd_byte == opc(opcode_set, mlk_pkg::OpcConnect)) begin
                  if (server_role && ex_ok) k_next = mlk_pkg::K_RESUME;
                end else if (cmd_byte == opc(opcode_set, mlk_pkg::OpcBye)) begin
                  if (ex_ok) begin
                    we = 1'b1;
                    wa = ex_id[IdBits-1:0];
                    k_next = mlk_pkg::K_BYE;
                  end
                end else begin
                  k_next = mlk_pkg::K_ERR;
                end
                if (k_next == mlk_pkg::K_ERR) closed_next = 1'b1;
                else c_next = mlk_pkg::C_NONE;
              end
            end
            mlk_pkg::PH_HDR: begin
              if (!hdr[1]) cmd_id_next = {cmd_id[7:0], byte_r};
              else rem_next = {rem[7:0], byte_r};
              if (hdr != 2'd3) begin
                hdr_next = hdr + 2'd1;
              end else begin
                hdr_next = 2'd0;
                if (rem_next == 16'd0) begin
                  phase_next = mlk_pkg::PH_CMD;
                  if (!ex_ok) begin
                    closed_next = 1'b1;
                    k_next = mlk_pkg::K_ERR;
                    c_next = mlk_pkg::C_DATA;
                    conn_next = cmd_id;
                  end
                end else begin
                  phase_next = mlk_pkg::PH_DATA;
                end
              end
            end
            mlk_pkg::PH_DATA: begin
              conn_next = cmd_id;
              if (!ex_ok) begin
                closed_next = 1'b1;
                k_next = mlk_pkg::K_ERR;
                c_next = mlk_pkg::C_DATA;
              end else begin
                rem_next = rem_dec;
                if (rem_dec == 16'd0) phase_next = mlk_pkg::PH_CMD;
                k_next = mlk_pkg::K_DATA;
                data_next = byte_r;
                last_next = (rem_dec == 16'd0);
              end
            end
            default: phase_next = mlk_pkg::PH_CMD;
          endcase
        end
        mlk_pkg::OP_TICK: begin
          idle_cnt_next = tick_cnt;
          if (tick_cnt == 8'd0) begin
            closed_next = 1'b1;
            k_next = mlk_pkg::K_IDLE;
          end else if (tick_cnt == ping_ticks) begin
            k_next = mlk_pkg::K_PING;
          end
        end
        mlk_pkg::OP_OPEN: begin
          first_id_next = next_id;
          k_next = mlk_pkg::K_OPENFAIL;
        end
        mlk_pkg::OP_REMOVE: begin
          if (ex_ok) begin
            we = 1'b1;
            wa = ex_id[IdBits-1:0];
            k_next = mlk_pkg::K_REMOVED;
            conn_next = ex_id;
          end
        end
        default: k_next = mlk_pkg::K_NONE;
      endcase
    end
    if (cmd.exec) ld = 1'b1;

    if (cmd.scan_rd) begin
      ra = cand;
      next_id_next = cand;
      if (cand == first_id) begin
        ld = 1'b1;
        k_next = mlk_pkg::K_OPENFAIL;
      end
    end

    if (cmd.scan_chk && !mem_q) begin
      we = 1'b1;
      wa = next_id;
      wd = 1'b1;
      ld = 1'b1;
      k_next = mlk_pkg::K_OPENED;
      conn_next = 16'(next_id);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    mem_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_role <= 1'b0;
      idle_ticks <= mlk_pkg::IdleTicksReset;
      ping_ticks <= mlk_pkg::PingTicksReset;
      opcode_set <= mlk_pkg::OpcodeSetReset;
      phase <= mlk_pkg::PH_CMD;
      hdr <= '0;
      cmd_byte <= '0;
      cmd_id <= '0;
      rem <= '0;
      idle_cnt <= mlk_pkg::IdleTicksReset;
      closed <= 1'b0;
      next_id <= '0;
      first_id <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mlk_pkg::RegServerRole: server_role <= cfg_data[0];
          mlk_pkg::RegIdleTicks:  idle_ticks <= cfg_data[7:0];
          mlk_pkg::RegPingTicks:  ping_ticks <= cfg_data[7:0];
          mlk_pkg::RegOpcodeSet:  opcode_set <= cfg_data;
          default: ;
        endcase
      end
      phase <= phase_next;
      hdr <= hdr_next;
      cmd_byte <= cmd_byte_next;
      cmd_id <= cmd_id_next;
      rem <= rem_next;
      idle_cnt <= idle_cnt_next;
      closed <= closed_next;
      next_id <= next_id_next;
      first_id <= first_id_next;
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_op;
      byte_r <= in_byte;
      lid_r <= in_lid;
    end
    if (ld) begin
      o_kind <= k_next;
      o_conn <= conn_next;
      o_data <= data_next;
      o_last <= last_next;
      o_cause <= c_next;
    end
  end

  a_closed_sticks: assert property (@(posedge clk) disable iff (rst)
    closed |=> closed) else $error("closed link reopened");
  a_last_data: assert property (@(posedge clk) disable iff (rst)
    ld && last_next |-> k_next == mlk_pkg::K_DATA) else $error("last on non-data result");
  a_cause_err: assert property (@(posedge clk) disable iff (rst)
    ld |-> ((c_next != mlk_pkg::C_NONE) == (k_next == mlk_pkg::K_ERR)))
    else $error("error cause mismatch");

endmodule

// ----- rtl/core/mux_link_deframer_keepalive_top.sv -----
// Top level of the multiplexed link receiver: link bytes, ticks, local open/remove.
// A taken request passes through an execute state, and for a local open in server
// role on an open link a bitmap scan, before its registered result is offered; the
// next request is accepted only once that result has been taken.
// A server-role local open probes the id bitmap one id at a time: read, then check.
// After reset a clearing pass sweeps every address of the bitmap memory;
// requests wait for it, configuration writes do not.
module mux_link_deframer_keepalive_top #(
  parameter int ID_BITS = mlk_pkg::IdBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  mlk_in_if.sink      in_ch,
  mlk_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  mlk_pkg::cmd_t cmd;
  mlk_pkg::sts_t sts;

  mlk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlk_dp #(.IdBits(ID_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (in_ch.op),
    .in_byte   (in_ch.byte_in),
    .in_lid    (in_ch.local_id),
    .cmd       (cmd),
    .sts       (sts),
    .o_kind    (out_ch.kind),
    .o_conn    (out_ch.conn_id),
    .o_data    (out_ch.data_out),
    .o_last    (out_ch.last),
    .o_cause   (out_ch.error_cause)
  );

endmodule

// ----- verif/mlk_link_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the multiplexed link receiver: keeps its own copy of the
// parser, id table and keepalive state. Depends on mlk_pkg and mlk_ifs.
module mlk_link_checker (
  input  logic        clk,
  input  logic        rst,
  mlk_in_if           in_ch,
  mlk_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] cid;
    logic [7:0]  dat;
    logic        lst;
    logic [1:0]  cause;
  } link_res_t;

  link_res_t   exp_q[$];

  logic        srv;
  logic [7:0]  idle_lim, ping_at, idle_cnt, cmd;
  logic [47:0] opc;
  mlk_pkg::phase_t ph;
  logic [1:0]  hcnt;
  logic [15:0] cid, remain, nxt;
  logic        closed;
  bit          id_tab[65536];

  assign pending = exp_q.size();

  function automatic logic [7:0] opb(input int n);
    return opc[8*n +: 8];
  endfunction

  function automatic link_res_t mk(input mlk_pkg::kind_t k, input logic [15:0] id,
                                   input logic [7:0] d, input logic l,
                                   input mlk_pkg::cause_t c);
    mk = '{k, id, d, l, c};
  endfunction

  task automatic close_err(input logic [15:0] id, input mlk_pkg::cause_t c,
                           output link_res_t r);
    closed = 1'b1;
    r = mk(mlk_pkg::K_ERR, id, 8'd0, 1'b0, c);
  endtask

  task automatic link_byte(input logic [7:0] b, output link_res_t r);
    r = mk(mlk_pkg::K_NONE, 16'd0, 8'd0, 1'b0, mlk_pkg::C_NONE);
    idle_cnt = idle_lim;
    case (ph)
      mlk_pkg::PH_CMD: begin
        cmd = b;
        hcnt = 2'd0;
        if (b == opb(mlk_pkg::OpcPing)) begin
          r = mk(mlk_pkg::K_PONG, 16'd0, 8'd0, 1'b0, mlk_pkg::C_NONE);
        end else if (b == opb(mlk_pkg::OpcPong)) ;
        else if (b == opb(mlk_pkg::OpcHello) || b == opb(mlk_pkg::OpcConnect) ||
                 b == opb(mlk_pkg::OpcBye)) ph = mlk_pkg::PH_CLIENT;
        else if (b == opb(mlk_pkg::OpcData)) ph = mlk_pkg::PH_HDR;
        else close_err(16'd0, mlk_pkg::C_UNKNOWN, r);
      end
      mlk_pkg::PH_CLIENT: begin
        cid = {cid[7:0], b};
        if (hcnt == 2'd0) begin
          hcnt = 2'd1;
        end else begin
          hcnt = 2'd0;
          ph = mlk_pkg::PH_CMD;
          if (cmd == opb(mlk_pkg::OpcHello)) begin
            if (srv || id_tab[cid]) close_err(cid, mlk_pkg::C_CLIENT, r);
            else begin
              id_tab[cid] = 1'b1;
              r = mk(mlk_pkg::K_ADDED, cid, 8'd0, 1'b0, mlk_pkg::C_NONE);
            end
          end else if (cmd == opb(mlk_pkg::OpcConnect)) begin
            if (!srv || !id_tab[cid]) close_err(cid, mlk_pkg::C_CLIENT, r);
            else r = mk(mlk_pkg::K_RESUME, cid, 8'd0, 1'b0, mlk_pkg::C_NONE);
          end else if (cmd == opb(mlk_pkg::OpcBye)) begin
            if (!id_tab[cid]) close_err(cid, mlk_pkg::C_CLIENT, r);
            else begin
              id_tab[cid] = 1'b0;
              r = mk(mlk_pkg::K_BYE, cid, 8'd0, 1'b0, mlk_pkg::C_NONE);
            end
          end else begin
            close_err(cid, mlk_pkg::C_CLIENT, r);
          end
        end
      end
      mlk_pkg::PH_HDR: begin
        if (hcnt < 2) cid = {cid[7:0], b};
        else remain = {remain[7:0], b};
        if (hcnt < 3) begin
          hcnt = hcnt + 2'd1;
        end else begin
          hcnt = 2'd0;
          if (remain == 16'd0) begin
            ph = mlk_pkg::PH_CMD;
            if (!id_tab[cid]) close_err(cid, mlk_pkg::C_DATA, r);
          end else begin
            ph = mlk_pkg::PH_DATA;
          end
        end
      end
      default: begin
        if (!id_tab[cid]) close_err(cid, mlk_pkg::C_DATA, r);
        else begin
          remain = remain - 16'd1;
          if (remain == 16'd0) ph = mlk_pkg::PH_CMD;
          r = mk(mlk_pkg::K_DATA, cid, b, remain == 16'd0, mlk_pkg::C_NONE);
        end
      end
    endcase
  endtask

  task automatic predict_link(input logic [1:0] op, input logic [7:0] b,
                              input logic [15:0] lid, output link_res_t r);
    logic [15:0] first;
    bit found;
    r = mk(mlk_pkg::K_NONE, 16'd0, 8'd0, 1'b0, mlk_pkg::C_NONE);
    if (closed) return;
    case (op)
      mlk_pkg::OP_LINK: link_byte(b, r);
      mlk_pkg::OP_TICK: begin
        idle_cnt = idle_cnt - 8'd1;
        if (idle_cnt == 8'd0) begin
          closed = 1'b1;
          r = mk(mlk_pkg::K_IDLE, 16'd0, 8'd0, 1'b0, mlk_pkg::C_NONE);
        end else if (idle_cnt == ping_at) begin
          r = mk(mlk_pkg::K_PING, 16'd0, 8'd0, 1'b0, mlk_pkg::C_NONE);
        end
      end
      mlk_pkg::OP_OPEN: begin
        r = mk(mlk_pkg::K_OPENFAIL, 16'd0, 8'd0, 1'b0, mlk_pkg::C_NONE);
        if (srv) begin
          first = nxt;
          found = 1'b0;
          do begin
            nxt = nxt + 16'd1;
            if (nxt != first && !id_tab[nxt]) found = 1'b1;
          end while (nxt != first && !found);
          if (found) begin
            id_tab[nxt] = 1'b1;
            r = mk(mlk_pkg::K_OPENED, nxt, 8'd0, 1'b0, mlk_pkg::C_NONE);
          end
        end
      end
      default: begin
        if (id_tab[lid]) begin
          id_tab[lid] = 1'b0;
          r = mk(mlk_pkg::K_REMOVED, lid, 8'd0, 1'b0, mlk_pkg::C_NONE);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    link_res_t r;
    if (rst) begin
      srv = 1'b0; idle_lim = mlk_pkg::IdleTicksReset; ping_at = mlk_pkg::PingTicksReset;
      opc = mlk_pkg::OpcodeSetReset; ph = mlk_pkg::PH_CMD; hcnt = 2'd0; cmd = 8'd0;
      cid = 16'd0; remain = 16'd0; idle_cnt = mlk_pkg::IdleTicksReset; closed = 1'b0;
      nxt = 16'd0;
      foreach (id_tab[i]) id_tab[i] = 1'b0;
      exp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mlk_pkg::RegServerRole: srv = cfg_data[0];
          mlk_pkg::RegIdleTicks:  idle_lim = cfg_data[7:0];
          mlk_pkg::RegPingTicks:  ping_at = cfg_data[7:0];
          default:                opc = cfg_data;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_link(in_ch.op, in_ch.byte_in, in_ch.local_id, r);
        exp_q.push_back(r);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got kind %0d id %0h",
                   $time, out_ch.kind, out_ch.conn_id);
        end else begin
          r = exp_q.pop_front();
          check_field("kind", r.kind, out_ch.kind);
          check_field("conn_id", r.cid, out_ch.conn_id);
          check_field("data_out", r.dat, out_ch.data_out);
          check_field("last", r.lst, out_ch.last);
          check_field("error_cause", r.cause, out_ch.error_cause);
        end
      end
    end
  end

  initial err_count = 0;

endmodule

// ----- verif/mux_link_deframer_keepalive_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the multiplexed link receiver: drives link bytes, ticks and
// local events with random gaps and stalls. Depends on mlk_pkg, mlk_ifs and mlk_link_checker.
module mux_link_deframer_keepalive_top_tb;

  localparam int Limit = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = mlk_pkg::RegServerRole;
  logic [47:0] cfg_data = '0;
  int          err_count, pending, n_sent, n_res, cycles, closure;
  bit          hold_req, no_idle;

  logic        g_srv;
  logic [7:0]  g_idle_lim, g_ping, g_idle;
  logic [47:0] g_opc;
  logic [15:0] g_next;
  bit          g_valid[65536];
  logic [15:0] known[$];

  mlk_in_if  in_ch();
  mlk_out_if out_ch();

  mux_link_deframer_keepalive_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mlk_link_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .err_count(err_count), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0; in_ch.op = mlk_pkg::OP_LINK; in_ch.byte_in = '0;
    in_ch.local_id = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (out_ch.valid && out_ch.ready) n_res++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("mux_link_deframer_keepalive_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int w;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      w = no_idle ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send(input mlk_pkg::op_t op, input logic [7:0] b, input logic [15:0] lid);
    int w;
    w = no_idle ? 0 : $urandom_range(0, 9);
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_ch.op <= op; in_ch.byte_in <= b; in_ch.local_id <= lid; in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (n_res != n_sent) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mlk_pkg::RegServerRole: g_srv = val[0];
      mlk_pkg::RegIdleTicks:  g_idle_lim = val[7:0];
      mlk_pkg::RegPingTicks:  g_ping = val[7:0];
      default:                g_opc = val;
    endcase
  endtask

  function automatic logic [7:0] opcode_of(input int n);
    return g_opc[8*n +: 8];
  endfunction

  task automatic link(input logic [7:0] b);
    send(mlk_pkg::OP_LINK, b, 16'($urandom));
    g_idle = g_idle_lim;
  endtask

  task automatic tick;
    send(mlk_pkg::OP_TICK, 8'($urandom), 16'($urandom));
    g_idle = g_idle - 8'd1;
  endtask

  task automatic forget(input logic [15:0] id);
    g_valid[id] = 1'b0;
    foreach (known[i]) if (known[i] == id) begin
      known.delete(i);
      break;
    end
  endtask

  task automatic local_open;
    logic [15:0] first;
    send(mlk_pkg::OP_OPEN, 8'($urandom), 16'($urandom));
    if (g_srv) begin
      first = g_next;
      do g_next = g_next + 16'd1; while (g_next != first && g_valid[g_next]);
      if (g_next != first) begin
        g_valid[g_next] = 1'b1;
        known.push_back(g_next);
      end
    end
  endtask

  task automatic local_remove(input logic [15:0] id);
    send(mlk_pkg::OP_REMOVE, 8'($urandom), id);
    if (g_valid[id]) forget(id);
  endtask

  task automatic client_cmd(input int opn, input logic [15:0] id);
    link(opcode_of(opn)); link(id[15:8]); link(id[7:0]);
    if (opn == mlk_pkg::OpcHello) begin
      g_valid[id] = 1'b1;
      known.push_back(id);
    end else if (opn == mlk_pkg::OpcBye) begin
      forget(id);
    end
  endtask

  task automatic frame(input logic [15:0] id, input logic [15:0] len);
    link(opcode_of(mlk_pkg::OpcData)); link(id[15:8]); link(id[7:0]);
    link(len[15:8]); link(len[7:0]);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0 && g_idle > 2) tick;
      link(8'($urandom));
    end
  endtask

  function automatic logic [15:0] fresh_id;
    logic [15:0] id;
    do id = 16'($urandom); while (g_valid[id]);
    return id;
  endfunction

  function automatic logic [15:0] pick_known;
    return known[$urandom_range(0, known.size() - 1)];
  endfunction

  task automatic random_step;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      if (g_idle > 2) tick; else link(opcode_of(mlk_pkg::OpcPing));
    end else if (r < 25) link(opcode_of(mlk_pkg::OpcPing));
    else if (r < 30) link(opcode_of(mlk_pkg::OpcPong));
    else if (r < 45 || known.size() == 0) begin
      if (!g_srv) client_cmd(mlk_pkg::OpcHello, fresh_id());
      else if (known.size() == 0) local_open();
      else client_cmd(mlk_pkg::OpcConnect, pick_known());
    end
    else if (r < 53) client_cmd(mlk_pkg::OpcBye, pick_known());
    else if (r < 78) frame(pick_known(), $urandom_range(0, 9) == 0 ?
                           16'($urandom_range(10, 40)) : 16'($urandom_range(1, 6)));
    else if (r < 86) local_open();
    else if (r < 90) local_remove(16'($urandom));
    else if (r < 94) local_remove(pick_known());
    else frame(pick_known(), 16'd0);
  endtask

  task automatic random_opcodes(output logic [47:0] v);
    logic [7:0] b[6];
    bit dup;
    foreach (b[i]) begin
      do begin
        b[i] = 8'($urandom);
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (b[j] == b[i]) dup = 1'b1;
      end while (dup);
    end
    v = {b[5], b[4], b[3], b[2], b[1], b[0]};
  endtask

  task automatic final_close;
    logic [7:0] bad;
    closure = $urandom_range(0, 4);
    case (closure)
      0: begin
        do bad = 8'($urandom);
        while (bad == opcode_of(mlk_pkg::OpcPing) || bad == opcode_of(mlk_pkg::OpcPong) ||
               bad == opcode_of(mlk_pkg::OpcHello) ||
               bad == opcode_of(mlk_pkg::OpcConnect) ||
               bad == opcode_of(mlk_pkg::OpcBye) || bad == opcode_of(mlk_pkg::OpcData));
        link(bad);
      end
      1: client_cmd(mlk_pkg::OpcBye, fresh_id());
      2: frame(fresh_id(), 16'd3);
      3: frame(fresh_id(), 16'd0);
      default: begin
        link(opcode_of(mlk_pkg::OpcPong));
        while (g_idle != 0) tick;
      end
    endcase
    repeat (12) begin
      random_step();
      if (known.size() == 0) link(opcode_of(mlk_pkg::OpcPing));
    end
  endtask

  initial begin
    logic [47:0] opc;
    g_srv = 1'b0; g_idle_lim = mlk_pkg::IdleTicksReset; g_ping = mlk_pkg::PingTicksReset;
    g_opc = mlk_pkg::OpcodeSetReset; g_idle = mlk_pkg::IdleTicksReset; g_next = 16'd0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    link(opcode_of(mlk_pkg::OpcPing));
    link(opcode_of(mlk_pkg::OpcPong));
    client_cmd(mlk_pkg::OpcHello, 16'h0000);
    client_cmd(mlk_pkg::OpcHello, 16'hFFFF);
    frame(16'hFFFF, 16'd1);
    frame(16'h0000, 16'd256);
    frame(16'hFFFF, 16'd0);
    local_open();
    local_remove(16'hFFFF);
    local_remove(16'h1234);
    client_cmd(mlk_pkg::OpcBye, 16'h0000);
    drain();

    hold_req = 1'b1;
    repeat (25) random_step();
    drain();

    cfg_write(mlk_pkg::RegServerRole, 48'd1);
    cfg_write(mlk_pkg::RegIdleTicks, 48'd20);
    cfg_write(mlk_pkg::RegPingTicks, 48'd15);
    no_idle = 1'b1;
    repeat (10) random_step();
    no_idle = 1'b0;
    repeat (15) random_step();
    drain();

    cfg_write(mlk_pkg::RegServerRole, 48'd0);
    cfg_write(mlk_pkg::RegIdleTicks, 48'd255);
    cfg_write(mlk_pkg::RegPingTicks, 48'd254);
    random_opcodes(opc);
    cfg_write(mlk_pkg::RegOpcodeSet, opc);
    link(opcode_of(mlk_pkg::OpcPong));
    tick();
    repeat (25) random_step();
    drain();

    cfg_write(mlk_pkg::RegIdleTicks, 48'd2);
    cfg_write(mlk_pkg::RegPingTicks, 48'd1);
    cfg_write(mlk_pkg::RegOpcodeSet, 48'hFFFF_FFFF_FFFF);
    link(8'hFF);
    tick();
    link(8'hFF);
    drain();
    cfg_write(mlk_pkg::RegOpcodeSet, 48'd0);
    link(8'h00);
    tick();
    link(8'h00);
    drain();
    cfg_write(mlk_pkg::RegIdleTicks, 48'd30);
    cfg_write(mlk_pkg::RegPingTicks, 48'd20);
    cfg_write(mlk_pkg::RegOpcodeSet, mlk_pkg::OpcodeSetReset);
    link(opcode_of(mlk_pkg::OpcPing));
    final_close();

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d requests and %0d results over %0d cycles", n_sent, n_res, cycles);
    $display("both roles, four register settings, link closed by case %0d", closure);
    if (err_count == 0 && pending == 0) begin
      $display("mux_link_deframer_keepalive_top_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", err_count, pending);
      $display("mux_link_deframer_keepalive_top_tb: done, errors");
    end
    $finish;
  end

endmodule
